/* rtl/ehp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Ethernet/IP header parser.
// No dependencies.
package ehp_pkg;

   localparam logic [15:0] MAX_FRAME_BYTES = 16'd16384;
   localparam int          EXT_UNIT_BYTES  = 8;

   localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
   localparam logic [15:0] ETYPE_IPV6     = 16'h86DD;
   localparam logic [15:0] ETYPE_VLAN_TAG = 16'h8100;

   localparam logic [7:0] IPPROTO_TCP      = 8'd6;
   localparam logic [7:0] IPPROTO_UDP      = 8'd17;
   localparam logic [7:0] PROTO_HOP_BY_HOP = 8'd0;
   localparam logic [7:0] PROTO_ROUTE_HDR  = 8'd43;
   localparam logic [7:0] PROTO_FRAG_HDR   = 8'd44;
   localparam logic [7:0] PROTO_ESP_HDR    = 8'd50;
   localparam logic [7:0] PROTO_AUTH_HDR   = 8'd51;
   localparam logic [7:0] PROTO_DEST_OPTS  = 8'd60;

   localparam logic [3:0] FIELD_LAST = 4'd15;

   typedef enum logic [8:0] {
      PH_ETH     = 9'b000000001,
      PH_VLAN    = 9'b000000010,
      PH_IP4     = 9'b000000100,
      PH_IP4_OPT = 9'b000001000,
      PH_IP6     = 9'b000010000,
      PH_IP6_EXT = 9'b000100000,
      PH_TCP     = 9'b001000000,
      PH_UDP     = 9'b010000000,
      PH_DONE    = 9'b100000000
   } phase_type;

   // Snapshot of one frame's captured fields.
   typedef struct packed {
      logic [15:0]      iface;
      logic [47:0]      dmac;
      logic [47:0]      smac;
      logic [15:0]      ethertype;
      logic [11:0]      vlan;
      logic [7:0]       proto;
      logic [3:0][63:0] addr;
      logic [3:0][15:0] ports;
      logic [15:0]      flags;
   } rec_type;

   function automatic logic [63:0] field_of(input rec_type r, input logic [3:0] k);
      logic [63:0] v;
      case (k)
         4'd0:    v = {48'd0, r.iface};
         4'd1:    v = {16'd0, r.dmac};
         4'd2:    v = {16'd0, r.smac};
         4'd3:    v = {48'd0, r.ethertype};
         4'd4:    v = {52'd0, r.vlan};
         4'd5:    v = {56'd0, r.proto};
         4'd6:    v = r.addr[0];
         4'd7:    v = r.addr[1];
         4'd8:    v = r.addr[0];
         4'd9:    v = r.addr[1];
         4'd10:   v = r.addr[2];
         4'd11:   v = r.addr[3];
         default: v = {48'd0, r.ports[k[1:0]]};
      endcase
      return v;
   endfunction

endpackage

/* rtl/ehp_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for frame bytes and field records.
// No dependencies.
interface ehp_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        frame_end;
   logic [15:0] interface_index;
   modport source(output valid, data_byte, frame_end, interface_index, input ready);
   modport sink(input valid, data_byte, frame_end, interface_index, output ready);
endinterface

interface ehp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  field_id;
   logic [63:0] field_value;
   logic        present;
   logic        run_last;
   modport source(output valid, field_id, field_value, present, run_last, input ready);
   modport sink(input valid, field_id, field_value, present, run_last, output ready);
endinterface

/* rtl/ethernet_ip_header_parser.sv */
`timescale 1ns / 1ps
// Ethernet/VLAN/IPv4/IPv6/TCP/UDP header parser, top level.
// Throughput: one frame byte per cycle unless the queue is full; each frame yields 16
// records, one per cycle while ready is high, queued as the frame's last byte is taken.
// A two-frame snapshot queue sets how long frames under 16 bytes may run before stalling.
// Reset (synchronous, active high) empties the queue and rewinds the walker.
module ethernet_ip_header_parser (
   input  logic      clock,
   input  logic      reset,
   ehp_req_if.sink   req_if,
   ehp_rsp_if.source rsp_if
);
   import ehp_pkg::*;

   logic    acc, push, full, pop, not_empty;
   rec_type snap, head;

   assign req_if.ready = !full;
   assign acc          = req_if.valid && req_if.ready;

   ehp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .acc             (acc),
      .data_byte       (req_if.data_byte),
      .frame_end       (req_if.frame_end),
      .interface_index (req_if.interface_index),
      .push            (push),
      .rec             (snap)
   );

   ehp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_rec    (snap),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .rd_rec    (head)
   );

   ehp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (not_empty),
      .head       (head),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

   a_id_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && !rsp_if.run_last |=>
         rsp_if.valid && rsp_if.field_id == $past(rsp_if.field_id) + 4'd1)
      else $error("field id did not advance within a run");

   a_full_has_output: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> rsp_if.valid)
      else $error("input stalled with no record pending");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("record offered right after reset");

endmodule

/* rtl/ehp_front.sv */
`timescale 1ns / 1ps
// Byte-serial header walker: one frame byte per accepted request.
// Depends on ehp_pkg.
module ehp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             acc,
   input  logic [7:0]       data_byte,
   input  logic             frame_end,
   input  logic [15:0]      interface_index,
   output logic             push,
   output ehp_pkg::rec_type rec
);
   import ehp_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [15:0]      offset_ff, offset_in;
   logic [15:0]      hstart_ff, hstart_in;
   logic [10:0]      hlen_ff, hlen_in;
   logic [7:0]       pnh_ff, pnh_in;
   logic [15:0]      hold_ff, hold_in;
   rec_type          rec_ff, rec_in;
   logic [15:0]      pos;
   logic [1:0]       word_sel;

   function automatic phase_type ph_of_et(input logic [15:0] et);
      phase_type p;
      if (et == ETYPE_IPV4) p = PH_IP4;
      else if (et == ETYPE_IPV6) p = PH_IP6;
      else if (et == ETYPE_VLAN_TAG) p = PH_VLAN;
      else p = PH_DONE;
      return p;
   endfunction

   function automatic phase_type ph_of_proto(input logic [7:0] p, input logic allow_ext);
      phase_type r;
      if (p == IPPROTO_TCP) r = PH_TCP;
      else if (p == IPPROTO_UDP) r = PH_UDP;
      else if (allow_ext && (p inside {PROTO_HOP_BY_HOP, PROTO_ROUTE_HDR, PROTO_FRAG_HDR,
                                       PROTO_ESP_HDR, PROTO_AUTH_HDR, PROTO_DEST_OPTS}))
         r = PH_IP6_EXT;
      else r = PH_DONE;
      return r;
   endfunction

   assign pos      = offset_ff - hstart_ff;
   assign word_sel = 2'((pos - 16'd8) >> 3);

   always_comb begin
      phase_in  = phase_ff;
      offset_in = offset_ff;
      hstart_in = hstart_ff;
      hlen_in   = hlen_ff;
      pnh_in    = pnh_ff;
      hold_in   = hold_ff;
      rec_in    = rec_ff;
      // first byte of a frame: restart the field set
      if (offset_ff == 16'd0) begin
         rec_in.vlan  = 12'd0;
         rec_in.flags = 16'h0001;
         rec_in.iface = interface_index;
      end
      if (offset_ff < MAX_FRAME_BYTES) begin
         offset_in = offset_ff + 16'd1;
         case (phase_ff)
            PH_ETH: begin
               if (pos < 16'd6) rec_in.dmac = {rec_ff.dmac[39:0], data_byte};
               else if (pos < 16'd12) rec_in.smac = {rec_ff.smac[39:0], data_byte};
               else if (pos == 16'd12) pnh_in = data_byte;
               else begin
                  rec_in.ethertype = {pnh_ff, data_byte};
                  rec_in.flags = rec_in.flags | 16'h000E;
                  phase_in = ph_of_et({pnh_ff, data_byte});
                  hstart_in = offset_in;
               end
            end
            PH_VLAN: begin
               if (pos < 16'd2) hold_in = {hold_ff[7:0], data_byte};
               else if (pos == 16'd2) pnh_in = data_byte;
               else begin
                  rec_in.ethertype = {pnh_ff, data_byte};
                  if (rec_in.vlan == 12'd0) rec_in.vlan = hold_ff[11:0];
                  rec_in.flags = rec_in.flags | 16'h0018;
                  phase_in = ph_of_et({pnh_ff, data_byte});
                  hstart_in = offset_in;
               end
            end
            PH_IP4: begin
               if (pos == 16'd0) hlen_in = {5'd0, data_byte[3:0], 2'b00};
               else if (pos == 16'd9) pnh_in = data_byte;
               else if (pos >= 16'd12 && pos < 16'd16)
                  rec_in.addr[0] = {32'd0, rec_ff.addr[0][23:0], data_byte};
               else if (pos >= 16'd16 && pos < 16'd20) begin
                  rec_in.addr[1] = {32'd0, rec_ff.addr[1][23:0], data_byte};
                  if (pos == 16'd19) begin
                     rec_in.proto = pnh_ff;
                     rec_in.flags = rec_in.flags | 16'h00E0;
                     if (hlen_ff < 11'd20) phase_in = PH_DONE;
                     else begin
                        hlen_in = hlen_ff - 11'd20;
                        if (hlen_ff == 11'd20) begin
                           phase_in = ph_of_proto(pnh_ff, 1'b0);
                           hstart_in = offset_in;
                        end else phase_in = PH_IP4_OPT;
                     end
                  end
               end
            end
            PH_IP4_OPT: begin
               hlen_in = hlen_ff - 11'd1;
               if (hlen_ff == 11'd1) begin
                  phase_in = ph_of_proto(pnh_ff, 1'b0);
                  hstart_in = offset_in;
               end
            end
            PH_IP6: begin
               if (pos == 16'd6) pnh_in = data_byte;
               else if (pos >= 16'd8 && pos < 16'd40) begin
                  rec_in.addr[word_sel] = {rec_ff.addr[word_sel][55:0], data_byte};
                  if (pos == 16'd39) begin
                     rec_in.proto = pnh_ff;
                     rec_in.flags = rec_in.flags | 16'h0F20;
                     phase_in = ph_of_proto(pnh_ff, 1'b1);
                     hstart_in = offset_in;
                  end
               end
            end
            PH_IP6_EXT: begin
               if (pos == 16'd0) pnh_in = data_byte;
               else if (pos == 16'd1) hlen_in = {data_byte, 3'b000} + 11'(EXT_UNIT_BYTES - 2);
               else begin
                  hlen_in = hlen_ff - 11'd1;
                  if (hlen_ff == 11'd1) begin
                     phase_in = ph_of_proto(pnh_ff, 1'b1);
                     hstart_in = offset_in;
                  end
               end
            end
            PH_TCP: begin
               if (pos < 16'd2) rec_in.ports[0] = {rec_ff.ports[0][7:0], data_byte};
               else if (pos < 16'd4) rec_in.ports[1] = {rec_ff.ports[1][7:0], data_byte};
               else if (pos == 16'd19) begin
                  rec_in.flags = rec_in.flags | 16'h3000;
                  phase_in = PH_DONE;
               end
            end
            PH_UDP: begin
               if (pos < 16'd2) rec_in.ports[2] = {rec_ff.ports[2][7:0], data_byte};
               else if (pos < 16'd4) rec_in.ports[3] = {rec_ff.ports[3][7:0], data_byte};
               else if (pos == 16'd7) begin
                  rec_in.flags = rec_in.flags | 16'hC000;
                  phase_in = PH_DONE;
               end
            end
            default: ;
         endcase
      end
      // frame end: rewind for the next frame
      if (frame_end) begin
         offset_in = 16'd0;
         hstart_in = 16'd0;
         phase_in  = PH_ETH;
      end
   end

   assign push = acc && frame_end;
   assign rec  = rec_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_ETH;
         offset_ff <= 16'd0;
         hstart_ff <= 16'd0;
         hlen_ff   <= 11'd0;
         pnh_ff    <= 8'd0;
         hold_ff   <= 16'd0;
         rec_ff    <= '0;
      end else if (acc) begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         hstart_ff <= hstart_in;
         hlen_ff   <= hlen_in;
         pnh_ff    <= pnh_in;
         hold_ff   <= hold_in;
         rec_ff    <= rec_in;
      end
   end

endmodule

/* rtl/ehp_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue of frame snapshots between the walker and the emitter.
// Depends on ehp_pkg.
module ehp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ehp_pkg::rec_type wr_rec,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output ehp_pkg::rec_type rd_rec
);
   import ehp_pkg::*;

   rec_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign rd_rec    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= wr_rec;
   end

endmodule

/* rtl/ehp_back.sv */
`timescale 1ns / 1ps
// Record emitter: walks field ids 0..15 over the queue head, one per response.
// Depends on ehp_pkg and ehp_rsp_if.
module ehp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  ehp_pkg::rec_type head,
   output logic             pop,
   ehp_rsp_if.source        rsp_if
);
   import ehp_pkg::*;

   logic [3:0] idx_ff, idx_in;
   logic       fire;

   assign fire              = rsp_if.valid && rsp_if.ready;
   assign rsp_if.valid       = head_valid;
   assign rsp_if.field_id    = idx_ff;
   assign rsp_if.present     = head.flags[idx_ff];
   assign rsp_if.field_value = head.flags[idx_ff] ? field_of(head, idx_ff) : 64'd0;
   assign rsp_if.run_last    = idx_ff == FIELD_LAST;
   // release the snapshot after its last record
   assign pop                = fire && idx_ff == FIELD_LAST;
   assign idx_in             = idx_ff + 4'd1;

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= 4'd0;
      else if (fire) idx_ff <= idx_in;
   end

endmodule

/* tb/ethernet_ip_header_parser_tb.sv */
`timescale 1ns / 1ps
// Testbench for the Ethernet/VLAN/IPv4/IPv6/TCP/UDP header parser: builds frames, predicts the
// 16 field records each frame yields and checks them in order.
// Depends on ehp_pkg, ehp_if and ethernet_ip_header_parser.
module ethernet_ip_header_parser_tb;
   import ehp_pkg::*;

   typedef struct {
      logic [3:0]  id;
      logic [63:0] value;
      logic        present;
      logic        last;
   } field_rec_type;

   typedef enum int {
      W_ETH, W_VLAN, W_IP4, W_IP4_OPT, W_IP6, W_IP6_EXT, W_TCP, W_UDP, W_DONE
   } walk_type;

   logic clock = 0;
   logic reset = 1;
   ehp_req_if req_if ();
   ehp_rsp_if rsp_if ();

   ethernet_ip_header_parser uut (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   field_rec_type expected_fields[$];
   int errors = 0;
   int frames_sent = 0;
   int records_seen = 0;
   int cycle_count = 0;
   bit idle_enable = 1;
   int hold_off_cycles = 0;
   int rsp_idle_left = 0;

   // predictor state
   walk_type    w_phase;
   int          w_offset, w_start, w_hlen;
   logic [7:0]  w_next;
   logic [47:0] w_dmac, w_smac;
   logic [15:0] w_etype, w_iface, w_tci;
   logic [11:0] w_vlan;
   logic [7:0]  w_proto;
   logic [63:0] w_addr[4];
   logic [15:0] w_ports[4];
   logic [15:0] w_flags;

   function automatic bit is_ext_hdr(logic [7:0] p);
      return p inside {PROTO_HOP_BY_HOP, PROTO_ROUTE_HDR, PROTO_FRAG_HDR,
                       PROTO_ESP_HDR, PROTO_AUTH_HDR, PROTO_DEST_OPTS};
   endfunction

   task automatic clear_walker();
      w_phase = W_ETH; w_offset = 0; w_start = 0; w_hlen = 0; w_next = 0;
      w_dmac = 0; w_smac = 0; w_etype = 0; w_iface = 0; w_tci = 0; w_vlan = 0;
      w_proto = 0; w_flags = 0;
      for (int i = 0; i < 4; i++) begin
         w_addr[i] = 0;
         w_ports[i] = 0;
      end
   endtask

   task automatic begin_header(walk_type ph);
      w_phase = ph;
      w_start = (w_offset + 1) & 16'hFFFF;
   endtask

   task automatic follow_ethertype(logic [15:0] et);
      if (et == ETYPE_IPV4) begin_header(W_IP4);
      else if (et == ETYPE_IPV6) begin_header(W_IP6);
      else if (et == ETYPE_VLAN_TAG) begin_header(W_VLAN);
      else w_phase = W_DONE;
   endtask

   task automatic follow_protocol(logic [7:0] p, bit allow_ext);
      if (p == IPPROTO_TCP) begin_header(W_TCP);
      else if (p == IPPROTO_UDP) begin_header(W_UDP);
      else if (allow_ext && is_ext_hdr(p)) begin_header(W_IP6_EXT);
      else w_phase = W_DONE;
   endtask

   task automatic walk_byte(logic [7:0] b);
      int pos;
      int w;
      pos = (w_offset - w_start) & 16'hFFFF;
      case (w_phase)
         W_ETH: begin
            if (pos < 6) w_dmac = {w_dmac[39:0], b};
            else if (pos < 12) w_smac = {w_smac[39:0], b};
            else if (pos == 12) w_next = b;
            else begin
               w_etype = {w_next, b};
               w_flags |= 16'h000E;
               follow_ethertype(w_etype);
            end
         end
         W_VLAN: begin
            if (pos < 2) w_tci = {w_tci[7:0], b};
            else if (pos == 2) w_next = b;
            else begin
               w_etype = {w_next, b};
               if (w_vlan == 0) w_vlan = w_tci[11:0];
               w_flags |= 16'h0018;
               follow_ethertype(w_etype);
            end
         end
         W_IP4: begin
            if (pos == 0) w_hlen = b[3:0] * 4;
            else if (pos == 9) w_next = b;
            else if (pos >= 12 && pos < 16) w_addr[0] = {32'd0, w_addr[0][23:0], b};
            else if (pos >= 16 && pos < 20) begin
               w_addr[1] = {32'd0, w_addr[1][23:0], b};
               if (pos == 19) begin
                  w_proto = w_next;
                  w_flags |= 16'h00E0;
                  if (w_hlen < 20) w_phase = W_DONE;
                  else begin
                     w_hlen -= 20;
                     if (w_hlen == 0) follow_protocol(w_next, 0);
                     else w_phase = W_IP4_OPT;
                  end
               end
            end
         end
         W_IP4_OPT: begin
            w_hlen = (w_hlen - 1) & 11'h7FF;
            if (w_hlen == 0) follow_protocol(w_next, 0);
         end
         W_IP6: begin
            if (pos == 6) w_next = b;
            else if (pos >= 8 && pos < 40) begin
               w = ((pos - 8) >> 3) & 3;
               w_addr[w] = {w_addr[w][55:0], b};
               if (pos == 39) begin
                  w_proto = w_next;
                  w_flags |= 16'h0F20;
                  follow_protocol(w_next, 1);
               end
            end
         end
         W_IP6_EXT: begin
            if (pos == 0) w_next = b;
            else if (pos == 1) w_hlen = b * EXT_UNIT_BYTES + (EXT_UNIT_BYTES - 2);
            else begin
               w_hlen = (w_hlen - 1) & 11'h7FF;
               if (w_hlen == 0) follow_protocol(w_next, 1);
            end
         end
         W_TCP: begin
            if (pos < 2) w_ports[0] = {w_ports[0][7:0], b};
            else if (pos < 4) w_ports[1] = {w_ports[1][7:0], b};
            else if (pos == 19) begin
               w_flags |= 16'h3000;
               w_phase = W_DONE;
            end
         end
         W_UDP: begin
            if (pos < 2) w_ports[2] = {w_ports[2][7:0], b};
            else if (pos < 4) w_ports[3] = {w_ports[3][7:0], b};
            else if (pos == 7) begin
               w_flags |= 16'hC000;
               w_phase = W_DONE;
            end
         end
         default: ;
      endcase
   endtask

   function automatic logic [63:0] captured_value(int k);
      case (k)
         0: return {48'd0, w_iface};
         1: return {16'd0, w_dmac};
         2: return {16'd0, w_smac};
         3: return {48'd0, w_etype};
         4: return {52'd0, w_vlan};
         5: return {56'd0, w_proto};
         6: return w_addr[0];
         7: return w_addr[1];
         8, 9, 10, 11: return w_addr[k - 8];
         default: return {48'd0, w_ports[(k - 12) & 3]};
      endcase
   endfunction

   task automatic predict_byte(logic [7:0] b, logic fend, logic [15:0] iface);
      field_rec_type r;
      if (w_offset == 0) begin
         clear_walker();
         w_iface = iface;
         w_flags = 16'h0001;
      end
      if (w_offset < MAX_FRAME_BYTES) begin
         walk_byte(b);
         w_offset = (w_offset + 1) & 16'hFFFF;
      end
      if (fend) begin
         for (int k = 0; k < 16; k++) begin
            r.id = 4'(k);
            r.present = w_flags[k];
            r.value = w_flags[k] ? captured_value(k) : 64'd0;
            r.last = (k == FIELD_LAST);
            expected_fields.push_back(r);
         end
         w_offset = 0;
         w_start = 0;
         w_phase = W_ETH;
      end
   endtask

   // drive one request; the prediction is made when it is accepted
   task automatic send_byte(logic [7:0] b, logic fend, logic [15:0] iface);
      if (idle_enable && $urandom_range(0, 9) == 0) begin
         req_if.valid <= 0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_if.valid <= 1;
      req_if.data_byte <= b;
      req_if.frame_end <= fend;
      req_if.interface_index <= iface;
      do @(posedge clock); while (!req_if.ready);
      predict_byte(b, fend, iface);
      if (fend) frames_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(logic [7:0] bytes[$], logic [15:0] iface);
      foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1, iface);
   endtask

   function automatic void add_rand(ref logic [7:0] q[$], input int n);
      for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void add_word(ref logic [7:0] q[$], input logic [15:0] v);
      q.push_back(v[15:8]);
      q.push_back(v[7:0]);
   endfunction

   // Ethernet with optional tags, IP header, optional extensions and transport
   function automatic void build_frame(ref logic [7:0] q[$], input int tags, input bit v6,
                                       input logic [7:0] proto, input int ihl, input int exts,
                                       input int tail);
      logic [7:0] nh;
      add_rand(q, 12);
      for (int t = 0; t < tags; t++) begin
         add_word(q, ETYPE_VLAN_TAG);
         add_word(q, (t == 0 && $urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom));
      end
      add_word(q, v6 ? ETYPE_IPV6 : ETYPE_IPV4);
      if (!v6) begin
         q.push_back({4'd4, ihl[3:0]});
         add_rand(q, 8);
         q.push_back(proto);
         add_rand(q, 10);
         add_rand(q, (ihl > 5) ? (ihl - 5) * 4 : 0);
      end else begin
         add_rand(q, 6);
         q.push_back(exts > 0 ? PROTO_HOP_BY_HOP : proto);
         add_rand(q, 33);
         for (int e = 0; e < exts; e++) begin
            case ($urandom_range(0, 4))
               0: nh = PROTO_ROUTE_HDR;
               1: nh = PROTO_FRAG_HDR;
               2: nh = PROTO_AUTH_HDR;
               3: nh = PROTO_ESP_HDR;
               default: nh = PROTO_DEST_OPTS;
            endcase
            if (e == exts - 1) nh = proto;
            q.push_back(nh);
            q.push_back(8'($urandom_range(0, 2)));
            add_rand(q, q[q.size() - 1] * 8 + 6);
         end
      end
      add_rand(q, tail);
   endfunction

   // response side: random idle bursts, long hold-off when asked
   always @(negedge clock) begin
      if (reset) rsp_if.ready <= 0;
      else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_if.ready <= 0;
      end else if (rsp_idle_left > 0) begin
         rsp_idle_left <= rsp_idle_left - 1;
         rsp_if.ready <= 0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
         rsp_idle_left <= $urandom_range(0, 6);
         rsp_if.ready <= 0;
      end else rsp_if.ready <= 1;
   end

   always @(posedge clock) begin
      field_rec_type e;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         records_seen++;
         if (expected_fields.size() == 0) begin
            $error("unexpected record field_id=%0d", rsp_if.field_id);
            errors++;
         end else begin
            e = expected_fields.pop_front();
            if (rsp_if.field_id !== e.id) begin
               $error("field_id exp %0d got %0d", e.id, rsp_if.field_id); errors++;
            end
            if (rsp_if.field_value !== e.value) begin
               $error("field_value (id %0d) exp %h got %h", e.id, e.value,
                      rsp_if.field_value);
               errors++;
            end
            if (rsp_if.present !== e.present) begin
               $error("present (id %0d) exp %b got %b", e.id, e.present, rsp_if.present);
               errors++;
            end
            if (rsp_if.run_last !== e.last) begin
               $error("run_last (id %0d) exp %b got %b", e.id, e.last, rsp_if.run_last);
               errors++;
            end
         end
      end
      if (cycle_count > 400000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[ethernet_ip_header_parser] ERROR");
         $finish;
      end
   end

   // drop valid and hold until every predicted record has come back
   task automatic wait_drained();
      req_if.valid <= 0;
      while (expected_fields.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      logic [7:0] q[$];
      // every-byte extremes: all-ones and all-zero frames
      q = {};
      repeat (14) q.push_back(8'hFF);
      send_frame(q, 16'hFFFF);
      q = {};
      repeat (3) q.push_back(8'h00);
      send_frame(q, 16'h0000);
      send_byte(8'hA5, 1, 16'h1234); // single-byte frame
      q = {}; build_frame(q, 0, 0, IPPROTO_TCP, 5, 0, 20); send_frame(q, 16'h0001);
      q = {}; build_frame(q, 1, 1, IPPROTO_UDP, 5, 1, 8); send_frame(q, 16'h8000);
      wait_drained();
   endtask

   task automatic test_backpressure();
      logic [7:0] q[$];
      hold_off_cycles = 300;
      for (int f = 0; f < 8; f++) begin
         q = {};
         add_rand(q, $urandom_range(1, 6));
         send_frame(q, 16'($urandom));
      end
      wait_drained();
   endtask

   task automatic test_random(int n_items, bit quiet);
      logic [7:0] q[$];
      int sent;
      logic [7:0] pr;
      sent = 0;
      idle_enable = !quiet;
      while (sent < n_items) begin
         q = {};
         case ($urandom_range(0, 9))
            0: add_rand(q, $urandom_range(1, 40));
            1: begin
               build_frame(q, $urandom_range(0, 2), $urandom_range(0, 1), IPPROTO_TCP, 5, 0, 20);
               q = q[0:$urandom_range(0, q.size() - 1)];
            end
            default: begin
               pr = $urandom_range(0, 3) == 0 ? IPPROTO_UDP :
                    ($urandom_range(0, 5) == 0 ? 8'($urandom_range(0, 255)) : IPPROTO_TCP);
               build_frame(q, $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0,
                           $urandom_range(0, 1), pr, $urandom_range(0, 15),
                           $urandom_range(0, 2), $urandom_range(0, 24));
            end
         endcase
         send_frame(q, 16'($urandom));
         sent += q.size();
      end
      wait_drained();
   endtask

   initial begin
      req_if.valid = 0;
      req_if.data_byte = 0;
      req_if.frame_end = 0;
      req_if.interface_index = 0;
      rsp_if.ready = 0;
      clear_walker();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_backpressure();
      test_random(50, 0);
      test_random(20, 1);
      repeat (20) @(negedge clock);
      $display("Covered %0d frames (%0d records): VLAN tags, IPv4 with and without options,",
               frames_sent, records_seen);
      $display("IPv6 extension chains, TCP/UDP, cut-off and unknown frames, under stalls.");
      if (errors == 0 && expected_fields.size() == 0)
         $display("[ethernet_ip_header_parser] OK");
      else
         $display("[ethernet_ip_header_parser] ERROR");
      $finish;
   end
endmodule
